// File: rtl/cos_pkg.sv
// Package for the clock offset servo: types, widths, register indexes and reset values.
// Used by cos_div, cos_ctrl, cos_dp, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cos_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 2'd2;

    localparam logic [30:0] STEP_THRESHOLD_RST = 31'd20000;
    localparam logic [5:0] SLEW_SHIFT_RST = 6'd4;
    localparam logic [31:0] STALE_LIMIT_RST = 32'd90000000;

    localparam logic [63:0] BILLION = 64'd1000000000;
    localparam int QUO_W = 64;
    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic load;
        logic prep;
        logic meas;
        logic anchor;
        logic mul;
        logic div_start;
        logic finish;
    } cos_cmd_t;

    typedef struct packed {
        logic div_need;
        logic div_done;
    } cos_status_t;

endpackage
`default_nettype wire

// File: rtl/cos_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on cos_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cos_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [63:0]                dividend,
    input  wire logic [31:0]                divisor,
    output logic                            done,
    output logic [cos_pkg::QUO_W-1:0]       quotient
);
    import cos_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[63]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = 7'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 32'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// File: rtl/cos_ctrl.sv
// Sequencing state machine of the clock offset servo.
// Depends on cos_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cos_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_mode,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output cos_pkg::cos_cmd_t         cmd,
    input  wire cos_pkg::cos_status_t sts
);
    import cos_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MEAS, S_APPLY, S_MUL, S_DIV, S_FINISH, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic ovalid_reg, ovalid_next;
    logic mode_reg, mode_next;

    always_comb
    begin
        state_next = state_reg;
        ovalid_next = ovalid_reg;
        mode_next = mode_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    mode_next = in_mode;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = mode_reg ? S_MEAS : S_FINISH;
            end
            S_MEAS:
            begin
                cmd.meas = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.anchor = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (sts.div_need)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                ovalid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ovalid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            mode_reg <= mode_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
endmodule
`default_nettype wire

// File: rtl/cos_dp.sv
// Datapath of the clock offset servo: time extension, offset servo, sample and divider.
// Depends on cos_pkg and cos_div.
`timescale 1ns / 1ps
`default_nettype none
module cos_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire cos_pkg::cos_cmd_t               cmd,
    output cos_pkg::cos_status_t                 sts,
    input  wire logic                            cfg_we,
    input  wire logic [cos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cos_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [31:0]                     raw_local_us,
    input  wire logic [63:0]                     ref_wall_us,
    output logic [63:0]                          wall_now_us,
    output logic                                 synced,
    output logic signed [63:0]                   offset_us,
    output logic signed [31:0]                   err_us,
    output logic signed [31:0]                   freq_err_ppb,
    output logic [31:0]                          interval_us,
    output logic [31:0]                          anchor_count,
    output logic                                 was_stepped,
    output logic                                 was_first,
    output logic                                 freq_ok,
    output logic                                 sample_valid
);
    import cos_pkg::*;

    logic [30:0] thr_reg;
    logic [5:0] shift_reg;
    logic [31:0] stale_reg;

    logic [31:0] raw_reg;
    logic [63:0] ref_reg;
    logic [31:0] last_raw_reg, wrap_reg;
    logic [63:0] local_reg, offset_reg, anchor_local_reg;
    logic [63:0] prev_off_reg, prev_local_reg;
    logic have_offset_reg, have_prev_reg, have_sample_reg;
    logic [31:0] seq_reg, s_err_reg, s_freq_reg, s_int_reg;
    logic [2:0] s_flags_reg;
    logic [63:0] meas_reg, dt_reg;
    logic [31:0] dm_reg;
    logic first_reg, stepped_reg, neg_reg, need_reg;
    logic [63:0] wall_reg;
    logic synced_reg;

    logic [63:0] diff, diff_mag, slew, dm, dm_mag;
    logic first, stepped;
    logic [63:0] prod;
    logic div_done;
    logic [QUO_W-1:0] quo;
    logic [31:0] sat_err, freq_val;
    logic [63:0] local_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= STEP_THRESHOLD_RST;
            shift_reg <= SLEW_SHIFT_RST;
            stale_reg <= STALE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_THRESHOLD: thr_reg <= cfg_data[30:0];
                CFG_SLEW_SHIFT: shift_reg <= cfg_data[5:0];
                CFG_STALE_LIMIT: stale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        diff = meas_reg - offset_reg;
        diff_mag = diff[63] ? (64'd0 - diff) : diff;
        slew = $signed(diff) >>> shift_reg;
        first = !have_offset_reg;
        stepped = first || (diff_mag > {33'd0, thr_reg});
        dm = meas_reg - prev_off_reg;
        dm_mag = dm[63] ? (64'd0 - dm) : dm;
        if (first)
        begin
            sat_err = '0;
        end
        else if (diff[63] && diff_mag > 64'h8000_0000)
        begin
            sat_err = 32'h8000_0000;
        end
        else if (!diff[63] && diff > 64'h7FFF_FFFF)
        begin
            sat_err = 32'h7FFF_FFFF;
        end
        else
        begin
            sat_err = diff[31:0];
        end
        prod = dm_reg * BILLION[31:0];
        if (neg_reg)
        begin
            freq_val = (quo > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
        end
        else
        begin
            freq_val = (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end
        local_now = {wrap_reg, last_raw_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= raw_local_us;
            ref_reg <= ref_wall_us;
        end
        if (cmd.prep)
        begin
            local_reg <= {wrap_reg + {31'd0, raw_reg < last_raw_reg}, raw_reg};
        end
        if (cmd.meas)
        begin
            meas_reg <= ref_reg - local_reg;
            dt_reg <= local_reg - prev_local_reg;
        end
        if (cmd.anchor)
        begin
            dm_reg <= dm_mag[31:0];
            neg_reg <= dm[63];
            first_reg <= first;
            stepped_reg <= stepped;
            need_reg <= have_prev_reg && !stepped && dt_reg != 64'd0
                && dt_reg[63:32] == 32'd0 && dm_mag <= BILLION;
        end
        if (cmd.finish)
        begin
            wall_reg <= local_now + offset_reg;
            synced_reg <= have_offset_reg && ((local_now - anchor_local_reg) < {32'd0, stale_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= '0;
            wrap_reg <= '0;
            offset_reg <= '0;
            have_offset_reg <= 1'b0;
            anchor_local_reg <= '0;
            have_prev_reg <= 1'b0;
            prev_off_reg <= '0;
            prev_local_reg <= '0;
            seq_reg <= '0;
            s_err_reg <= '0;
            s_freq_reg <= '0;
            s_int_reg <= '0;
            s_flags_reg <= '0;
            have_sample_reg <= 1'b0;
        end
        else
        begin
            if (cmd.prep)
            begin
                if (raw_reg < last_raw_reg)
                begin
                    wrap_reg <= wrap_reg + 32'd1;
                end
                last_raw_reg <= raw_reg;
            end
            if (cmd.anchor)
            begin
                offset_reg <= stepped ? meas_reg : (offset_reg + slew);
                have_offset_reg <= 1'b1;
                anchor_local_reg <= local_reg;
                s_err_reg <= sat_err;
                s_int_reg <= !have_prev_reg ? 32'd0
                    : ((dt_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : dt_reg[31:0]);
                have_prev_reg <= 1'b1;
                prev_off_reg <= meas_reg;
                prev_local_reg <= local_reg;
                seq_reg <= seq_reg + 32'd1;
                have_sample_reg <= 1'b1;
            end
            if (cmd.mul)
            begin
                s_freq_reg <= '0;
                s_flags_reg <= {1'b0, first_reg, stepped_reg};
            end
            if (div_done)
            begin
                s_freq_reg <= freq_val;
                s_flags_reg[2] <= 1'b1;
            end
        end
    end

    cos_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod),
        .divisor  (dt_reg[31:0]),
        .done     (div_done),
        .quotient (quo)
    );

    assign sts.div_need = need_reg;
    assign sts.div_done = div_done;

    assign wall_now_us = wall_reg;
    assign synced = synced_reg;
    assign offset_us = offset_reg;
    assign err_us = s_err_reg;
    assign freq_err_ppb = s_freq_reg;
    assign interval_us = s_int_reg;
    assign anchor_count = seq_reg;
    assign was_stepped = s_flags_reg[0];
    assign was_first = s_flags_reg[1];
    assign freq_ok = s_flags_reg[2];
    assign sample_valid = have_sample_reg;
endmodule
`default_nettype wire

// File: rtl/clock_offset_step_slew_servo_core.sv
// Clock offset servo with step and slew; one item in flight at a time.
// A clock read passes PREP and FINISH before it offers its result for taking; an anchor
// without a frequency estimate passes PREP, MEAS, APPLY, MUL and FINISH, and an anchor
// with one also waits in DIV for the one-bit-per-cycle 64-bit divider that forms the
// ppb figure. The next item is accepted only after the result is taken and the block
// is back in idle; a stalled output holds the block in its output state.
// Depends on cos_pkg, cos_ctrl and cos_dp.
`timescale 1ns / 1ps
`default_nettype none
module clock_offset_step_slew_servo_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [cos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cos_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            mode,
    input  wire logic [31:0]                     raw_local_us,
    input  wire logic [63:0]                     ref_wall_us,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [63:0]                          wall_now_us,
    output logic                                 synced,
    output logic signed [63:0]                   offset_us,
    output logic signed [31:0]                   err_us,
    output logic signed [31:0]                   freq_err_ppb,
    output logic [31:0]                          interval_us,
    output logic [31:0]                          anchor_count,
    output logic                                 was_stepped,
    output logic                                 was_first,
    output logic                                 freq_ok,
    output logic                                 sample_valid
);
    import cos_pkg::*;

    cos_cmd_t cmd;
    cos_status_t sts;

    cos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    cos_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .raw_local_us (raw_local_us),
        .ref_wall_us  (ref_wall_us),
        .wall_now_us  (wall_now_us),
        .synced       (synced),
        .offset_us    (offset_us),
        .err_us       (err_us),
        .freq_err_ppb (freq_err_ppb),
        .interval_us  (interval_us),
        .anchor_count (anchor_count),
        .was_stepped  (was_stepped),
        .was_first    (was_first),
        .freq_ok      (freq_ok),
        .sample_valid (sample_valid)
    );
endmodule
`default_nettype wire

// File: rtl/cos_checker.sv
// Port-level checker for the clock offset servo, bound to the top level.
// Depends on clock_offset_step_slew_servo_core.
`timescale 1ns / 1ps
`default_nettype none
module cos_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] anchor_count,
    input wire logic        sample_valid,
    input wire logic        was_first,
    input wire logic        freq_ok,
    input wire logic        was_stepped
);
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sample_valid |-> anchor_count == 32'd0)
        else $error("anchors without sample");
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_first |-> was_stepped && !freq_ok)
        else $error("first anchor flags inconsistent");
endmodule

bind clock_offset_step_slew_servo_core cos_checker u_cos_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .anchor_count (anchor_count),
    .sample_valid (sample_valid),
    .was_first    (was_first),
    .freq_ok      (freq_ok),
    .was_stepped  (was_stepped)
);
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for clock_offset_step_slew_servo_core: drives directed and random
// clock reads and anchors, predicts every result in-line and compares field by field.
// Depends on cos_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
    import cos_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [63:0] wall;
        logic        sync;
        logic [63:0] offs;
        logic [31:0] err;
        logic [31:0] freq;
        logic [31:0] intv;
        logic [31:0] cnt;
        logic        stepped;
        logic        first;
        logic        fok;
        logic        svalid;
    } servo_res_t;

    typedef struct {
        logic        md;
        logic [31:0] raw;
        logic [63:0] ref_t;
        logic        chk;
        logic [31:0] x_err;
        logic [31:0] x_intv;
        logic        x_stepped;
        logic        x_first;
        logic        x_fok;
        logic        x_svalid;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [31:0] raw_local_us = '0;
    logic [63:0] ref_wall_us = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [63:0] wall_now_us;
    logic synced;
    logic signed [63:0] offset_us;
    logic signed [31:0] err_us;
    logic signed [31:0] freq_err_ppb;
    logic [31:0] interval_us;
    logic [31:0] anchor_count;
    logic was_stepped;
    logic was_first;
    logic freq_ok;
    logic sample_valid;

    clock_offset_step_slew_servo_core DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predicted servo state and configuration.
    logic [30:0] thr_q;
    logic [5:0]  shift_q;
    logic [31:0] stale_q;
    logic [31:0] raw_prev, wraps, n_anchor, s_err, s_freq, s_intv;
    logic [63:0] offs_q, anchor_loc, pm_offs, pm_loc;
    logic        have_offs, have_pm, have_s, s_step, s_first, s_fok;

    servo_res_t expected_q[$];
    int errors = 0;
    int n_results = 0;
    int n_anchors_sent = 0;
    int send_idle = 0;
    int recv_idle = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        if (v[63]) return (mag(v) > 64'h8000_0000) ? 32'h8000_0000 : v[31:0];
        return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

    task automatic servo_predict(input logic md, input logic [31:0] raw, input logic [63:0] rt);
        logic [63:0] loc, meas, diff, dt, dm, q;
        servo_res_t r;
        diff = '0;
        if (raw < raw_prev) wraps++;
        raw_prev = raw;
        loc = {wraps, raw};
        if (md)
        begin
            meas = rt - loc;
            s_first = !have_offs;
            s_step = 1'b0;
            s_fok = 1'b0;
            s_err = '0;
            s_freq = '0;
            s_intv = '0;
            if (!have_offs)
            begin
                offs_q = meas;
                have_offs = 1'b1;
                s_step = 1'b1;
            end
            else
            begin
                diff = meas - offs_q;
                if (mag(diff) > {33'd0, thr_q})
                begin
                    offs_q = meas;
                    s_step = 1'b1;
                end
                else
                    offs_q = offs_q + 64'($signed(diff) >>> shift_q);
            end
            anchor_loc = loc;
            if (!s_first) s_err = clamp32(diff);
            if (have_pm)
            begin
                dt = loc - pm_loc;
                dm = meas - pm_offs;
                s_intv = (dt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dt[31:0];
                if (!s_step && dt != 0 && dt <= 64'hFFFF_FFFF && mag(dm) <= BILLION)
                begin
                    q = (mag(dm) * BILLION) / dt;
                    if (dm[63]) s_freq = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
                    else s_freq = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
                    s_fok = 1'b1;
                end
            end
            pm_offs = meas;
            pm_loc = loc;
            have_pm = 1'b1;
            n_anchor++;
            have_s = 1'b1;
        end
        r.wall = loc + offs_q;
        r.sync = have_offs && ((loc - anchor_loc) < {32'd0, stale_q});
        r.offs = offs_q;
        r.err = have_s ? s_err : '0;
        r.freq = have_s ? s_freq : '0;
        r.intv = have_s ? s_intv : '0;
        r.cnt = n_anchor;
        r.stepped = have_s & s_step;
        r.first = have_s & s_first;
        r.fok = have_s & s_fok;
        r.svalid = have_s;
        expected_q.push_back(r);
    endtask

    task automatic send_item(input logic md, input logic [31:0] raw, input logic [63:0] rt);
        servo_predict(md, raw, rt);
        if (md) n_anchors_sent++;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        raw_local_us <= raw;
        ref_wall_us <= rt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STEP_THRESHOLD: thr_q = val[30:0];
            CFG_SLEW_SHIFT: shift_q = val[5:0];
            CFG_STALE_LIMIT: stale_q = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        servo_res_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("unexpected result %0d", n_results);
                errors++;
            end
            else
            begin
                w = expected_q.pop_front();
                if (wall_now_us !== w.wall) report("wall_now_us", wall_now_us, w.wall);
                if (synced !== w.sync) report("synced", 64'(synced), 64'(w.sync));
                if (offset_us !== w.offs) report("offset_us", offset_us, w.offs);
                if (err_us !== w.err) report("err_us", 64'(err_us), 64'(w.err));
                if (freq_err_ppb !== w.freq)
                    report("freq_err_ppb", 64'(freq_err_ppb), 64'(w.freq));
                if (interval_us !== w.intv)
                    report("interval_us", 64'(interval_us), 64'(w.intv));
                if (anchor_count !== w.cnt)
                    report("anchor_count", 64'(anchor_count), 64'(w.cnt));
                if (was_stepped !== w.stepped)
                    report("was_stepped", 64'(was_stepped), 64'(w.stepped));
                if (was_first !== w.first) report("was_first", 64'(was_first), 64'(w.first));
                if (freq_ok !== w.fok) report("freq_ok", 64'(freq_ok), 64'(w.fok));
                if (sample_valid !== w.svalid)
                    report("sample_valid", 64'(sample_valid), 64'(w.svalid));
            end
            n_results++;
        end
    end

    // Directed rows; where a row's check flag is set, its typed expectations are checked against the predicted values.
    row_t rows[$];

    task automatic add_row(input logic md, input logic [31:0] raw, input logic [63:0] rt,
                           input logic chk, input logic [31:0] e, input logic [31:0] iv,
                           input logic st, input logic fi, input logic fo, input logic sv);
        row_t r;
        r = '{md, raw, rt, chk, e, iv, st, fi, fo, sv};
        rows.push_back(r);
    endtask

    task automatic run_phase(input int n);
        logic [63:0] base;
        logic [31:0] raw;
        int k;
        base = {$urandom, $urandom};
        raw = $urandom;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: send_item(1'($urandom_range(1)), $urandom, {$urandom, $urandom});
                1: begin
                    raw = raw + $urandom_range(200000);
                    send_item(1'b1, raw, {32'd0, raw} + base + 64'($signed($urandom) >>> 2));
                end
                2, 3, 4: begin
                    raw = raw + $urandom_range(1000000);
                    send_item(1'b1, raw,
                              {32'd0, raw} + base + 64'($signed(32'($urandom_range(4000))) - 2000));
                end
                default: begin
                    raw = raw + $urandom_range(3000000);
                    send_item(1'b0, raw, {$urandom, $urandom});
                end
            endcase
        end
    endtask

    initial
    begin
        servo_res_t w;
        int i;
        thr_q = STEP_THRESHOLD_RST;
        shift_q = SLEW_SHIFT_RST;
        stale_q = STALE_LIMIT_RST;
        raw_prev = '0; wraps = '0; n_anchor = '0; s_err = '0; s_freq = '0; s_intv = '0;
        offs_q = '0; anchor_loc = '0; pm_offs = '0; pm_loc = '0;
        have_offs = 1'b0; have_pm = 1'b0; have_s = 1'b0;
        s_step = 1'b0; s_first = 1'b0; s_fok = 1'b0;

        add_row(1'b0, 32'd100, 64'd0, 1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd1000, 64'd5000, 1'b1, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b1);
        add_row(1'b1, 32'd2000, 64'd6010, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd3000, 64'd7000, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd3000, 64'd7000, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd4000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 32'd0,
                1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd5000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'd1000,
                1'b1, 1'b0, 1'b0, 1'b1);
        add_row(1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 32'd0,
                1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b0, 32'd0, 64'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd10, 64'h8000_0000_0000_0000, 1'b0, 32'd0, 32'd0,
                1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd20, 64'h8000_0000_0000_0100, 1'b0, 32'd0, 32'd0,
                1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 32'd30, 64'h8000_0000_0000_0100, 1'b0, 32'd0, 32'd0,
                1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b0, 32'hFFFF_0000, 64'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(1'b0, 32'h0000_0005, 64'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < rows.size(); i++)
        begin
            send_item(rows[i].md, rows[i].raw, rows[i].ref_t);
            if (rows[i].chk)
            begin
                w = expected_q[$];
                if (w.err !== rows[i].x_err || w.intv !== rows[i].x_intv
                    || w.stepped !== rows[i].x_stepped || w.first !== rows[i].x_first
                    || w.fok !== rows[i].x_fok || w.svalid !== rows[i].x_svalid)
                begin
                    $display("directed row %0d disagrees with its typed expectation", i);
                    errors++;
                end
            end
        end
        drain();

        write_cfg(CFG_STEP_THRESHOLD, 32'h7FFF_FFFF);
        write_cfg(CFG_SLEW_SHIFT, 32'd0);
        write_cfg(CFG_STALE_LIMIT, 32'hFFFF_FFFF);
        send_idle = 9; recv_idle = 77;
        run_phase(250);
        drain();

        write_cfg(CFG_STEP_THRESHOLD, 32'd0);
        write_cfg(CFG_SLEW_SHIFT, 32'd63);
        write_cfg(CFG_STALE_LIMIT, 32'd0);
        write_cfg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        send_idle = 77; recv_idle = 9;
        run_phase(200);
        drain();

        write_cfg(CFG_STEP_THRESHOLD, 32'd3000);
        write_cfg(CFG_SLEW_SHIFT, $urandom_range(1, 8));
        write_cfg(CFG_STALE_LIMIT, 32'd2500000);
        send_idle = 0; recv_idle = 0;
        run_phase(300);
        drain();

        write_cfg(CFG_STEP_THRESHOLD, $urandom);
        write_cfg(CFG_SLEW_SHIFT, $urandom);
        write_cfg(CFG_STALE_LIMIT, $urandom);
        run_phase(250);
        drain();

        $display("tb: %0d results checked, %0d anchors sent, four register settings.",
                 n_results, n_anchors_sent);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: PASS");
        else
        begin
            if (expected_q.size() != 0) $display("%0d results never arrived", expected_q.size());
            $display("tb: FAIL");
        end
        $finish;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("tb: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
rtl/cos_pkg.sv
rtl/cos_div.sv
rtl/cos_ctrl.sv
rtl/cos_dp.sv
rtl/clock_offset_step_slew_servo_core.sv
rtl/cos_checker.sv
sim/tb.sv
